@@ rtl/core/uwdt_pkg.sv @@
// Package for the unlockable watchdog timer core: beat modes, register
// indexes, command words and control bit positions. No dependencies.
package uwdt_pkg;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_COMMAND = 3'd1;
    localparam logic [2:0] REG_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_WINDOW  = 3'd3;

    localparam logic [31:0] UNLOCK_WORD  = 32'hd928c520;
    localparam logic [31:0] REFRESH_WORD = 32'hb480a602;

    localparam int BIT_EN    = 7;
    localparam int BIT_RCS   = 10;
    localparam int BIT_ULK   = 11;
    localparam int BIT_PRES  = 12;
    localparam int BIT_CMD32 = 13;

    localparam logic [31:0] CONTROL_RESET = 32'h0000_2000;

    // With the prescaler the count is floor(timeout * 1000 / 3); it is held
    // as a scaled value that drops by three per tick, so the counter is wider.
    localparam int CNT_W = 42;
    localparam logic [CNT_W-1:0] TICK_SCALE = CNT_W'(1000);

endpackage

@@ rtl/core/unlockable_watchdog_timer_core.sv @@
// Unlockable watchdog timer core: four word registers behind a beat stream.
// Each result beat is registered, valid in the cycle after its beat is taken;
// one beat is accepted every cycle unless m_tready stalls the output register.
// Synchronous active-low reset: control reads 0x2000, all else zero, locked
// and disarmed. Depends on uwdt_pkg.
module unlockable_watchdog_timer_core
    import uwdt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // write_data
    input  logic [4:0]  s_tuser,   // mode [1:0], reg_index [4:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data
    output logic [1:0]  m_tuser    // timeout_fired [0], bad_address [1]
);

    logic [31:0]      control_reg, control_next;
    logic [31:0]      timeout_reg, timeout_next;
    logic [31:0]      window_reg, window_next;
    logic             unlocked_reg, unlocked_next;
    logic             rcs_reg, rcs_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pres_reg, pres_next;
    logic             armed_reg, armed_next;

    logic             m_valid_reg;
    logic [31:0]      m_data_reg, m_data_next;
    logic             fired_reg, fired_next;
    logic             bad_reg, bad_next;

    logic             accept;
    mode_t            mode;
    logic [2:0]       idx;
    logic [31:0]      wdata;

    logic [31:0]      arm_ctrl;
    logic             arm_req;
    logic [CNT_W-1:0] scaled_timeout;
    logic             count_end;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser[1:0]);
    assign idx      = s_tuser[4:2];
    assign wdata    = s_tdata;

    assign scaled_timeout = CNT_W'(timeout_reg) * TICK_SCALE;
    assign count_end      = pres_reg ? (count_reg <= CNT_W'(5)) : (count_reg <= CNT_W'(1));

    always_comb begin
        control_next  = control_reg;
        timeout_next  = timeout_reg;
        window_next   = window_reg;
        unlocked_next = unlocked_reg;
        rcs_next      = rcs_reg;
        count_next    = count_reg;
        pres_next     = pres_reg;
        armed_next    = armed_reg;
        m_data_next   = '0;
        fired_next    = 1'b0;
        bad_next      = 1'b0;
        arm_req       = 1'b0;
        arm_ctrl      = control_reg;

        unique case (mode)
            MODE_READ: begin
                unique case (idx)
                    REG_CONTROL: begin
                        m_data_next          = control_reg;
                        m_data_next[BIT_ULK] = unlocked_reg;
                        m_data_next[BIT_RCS] = rcs_reg;
                    end
                    REG_COMMAND: m_data_next = '0;
                    REG_TIMEOUT: m_data_next = timeout_reg;
                    REG_WINDOW:  m_data_next = window_reg;
                    default:     bad_next    = 1'b1;
                endcase
            end
            MODE_WRITE: begin
                unique case (idx)
                    REG_CONTROL: begin
                        if (unlocked_reg) begin
                            control_next          = wdata;
                            control_next[BIT_ULK] = 1'b0;
                            control_next[BIT_RCS] = 1'b0;
                            unlocked_next         = 1'b0;
                            rcs_next              = 1'b1;
                            arm_req               = 1'b1;
                            arm_ctrl              = wdata;
                        end
                    end
                    REG_COMMAND: begin
                        if (wdata == UNLOCK_WORD) begin
                            unlocked_next = 1'b1;
                            rcs_next      = 1'b0;
                        end else if (wdata == REFRESH_WORD) begin
                            arm_req = 1'b1;
                        end
                    end
                    REG_TIMEOUT: begin
                        if (unlocked_reg) begin
                            timeout_next = wdata;
                        end
                    end
                    REG_WINDOW: begin
                        if (unlocked_reg) begin
                            window_next = wdata;
                        end
                    end
                    default: bad_next = 1'b1;
                endcase
            end
            MODE_TICK: begin
                if (armed_reg) begin
                    if (count_end) begin
                        count_next = '0;
                        armed_next = 1'b0;
                        fired_next = 1'b1;
                    end else begin
                        count_next = count_reg - (pres_reg ? CNT_W'(3) : CNT_W'(1));
                    end
                end
            end
            default: begin
            end
        endcase

        if (arm_req) begin
            if (arm_ctrl[BIT_EN] && (timeout_reg != '0)) begin
                armed_next = 1'b1;
                pres_next  = arm_ctrl[BIT_PRES];
                count_next = arm_ctrl[BIT_PRES] ? scaled_timeout : CNT_W'(timeout_reg);
            end else begin
                armed_next = 1'b0;
                pres_next  = 1'b0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg  <= CONTROL_RESET;
            timeout_reg  <= '0;
            window_reg   <= '0;
            unlocked_reg <= 1'b0;
            rcs_reg      <= 1'b0;
            count_reg    <= '0;
            pres_reg     <= 1'b0;
            armed_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                control_reg  <= control_next;
                timeout_reg  <= timeout_next;
                window_reg   <= window_next;
                unlocked_reg <= unlocked_next;
                rcs_reg      <= rcs_next;
                count_reg    <= count_next;
                pres_reg     <= pres_next;
                armed_reg    <= armed_next;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            fired_reg  <= fired_next;
            bad_reg    <= bad_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {bad_reg, fired_reg};

endmodule

@@ rtl/core/uwdt_checker.sv @@
// Port-level checks for the unlockable watchdog timer core, bound into that
// module. Depends on unlockable_watchdog_timer_core.
module uwdt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result beat valid straight after reset.");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("Accepted beat produced no result beat.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result beat changed.");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("Timeout and bad address flagged on one beat.");

    a_bad_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
        else $error("Bad address beat carries non-zero data.");

endmodule

bind unlockable_watchdog_timer_core uwdt_checker u_uwdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
